FILE: rtl/dmc_pkg.sv
// shared types, constants and round tables for the container checksum
`default_nettype none
package dmc_pkg;

  localparam int unsigned HdrBytes = 20;
  localparam logic [7:0]  PadByte  = 8'h80;

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;

  // queue entry from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hdr;
  } dmc_item_t;

  // block buffer fill control
  typedef struct packed {
    logic       wr;
    logic [5:0] addr;
    logic [7:0] data;
  } dmc_wr_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
      4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
      4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word used by round i
  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/dxbc_md5_checksum.sv
// top level of the shader container checksum
//
// usage:
//   s_axis carries one container byte per transfer, tlast on the final byte.
//   m_axis returns the four state words a, b, c, d, tlast on word d.
//   the first twenty bytes are skipped; the rest is hashed in 64-byte blocks.
// operation:
//   an ordinary byte is popped and written to the block ram in the idle state; the
//   byte that fills a block starts 64 rounds, each made of four single-byte ram
//   reads for its message word followed by the round itself.
//   the final byte builds a 64-byte tail block and runs it, once
//   or twice, then the four words leave one per cycle while m_axis_tready is high.
//   a two-entry queue lets bytes be taken while the engine is busy.
// reset:
//   all control state and the chaining words return to their start values;
//   after the fourth word the block is ready for the next container.
//   a stalled m_axis_tready holds the current word and pauses the engine.
`default_nettype none
module dxbc_md5_checksum import dmc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // digest_word [31:0], word_index [33:32], zeros
  output logic             m_axis_tlast    // last_word
);
  logic      q_valid, q_pop;
  dmc_item_t q_item;
  logic [31:0] word;
  logic [1:0]  idx;

  dmc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .data_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .q_valid_o(q_valid),
    .q_pop_i  (q_pop),
    .q_item_o (q_item)
  );

  dmc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_item_i   (q_item),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .word_o     (word),
    .index_o    (idx),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, idx, word};
endmodule
`default_nettype wire

FILE: rtl/dmc_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module dmc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/dmc_front.sv
// input side: header marking and a two-entry queue towards the hash engine
`default_nettype none
module dmc_front import dmc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire logic [7:0] data_i,
  input  wire logic      last_i,
  output logic           q_valid_o,
  input  wire logic      q_pop_i,
  output dmc_item_t      q_item_o
);
  logic [4:0] hdr_q, hdr_d;
  dmc_item_t  ent_q [2];
  logic [1:0] cnt_q;
  logic       rp_q, wp_q;
  logic       push, pop;

  assign ready_o   = (cnt_q != 2'd2);
  assign push      = valid_i && ready_o;
  assign pop       = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = ent_q[rp_q];

  always_comb begin
    hdr_d = hdr_q;
    if (push) begin
      if (last_i) hdr_d = '0;
      else if (hdr_q < 5'(HdrBytes)) hdr_d = hdr_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= '{data: data_i, last: last_i, hdr: (hdr_q < 5'(HdrBytes))};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= '0;
      cnt_q <= '0;
      rp_q  <= 1'b0;
      wp_q  <= 1'b0;
    end else begin
      hdr_q <= hdr_d;
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/dmc_back.sv
// hash engine: block fill, padding, iterative md5 rounds and word output
`default_nettype none
module dmc_back import dmc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      q_valid_i,
  output logic           q_pop_o,
  input  dmc_item_t      q_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output logic [31:0]    word_o,
  output logic [1:0]     index_o,
  output logic           last_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StBuild = 3'd1;  // write padded final block into ram
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StOut = 3'd3;

  // which block the rounds are working on
  localparam logic [2:0] PhNormal = 3'd0;  // full payload block
  localparam logic [2:0] PhShort  = 3'd1;  // single closing block with length words
  localparam logic [2:0] PhFirst  = 3'd2;  // padded leftover, length block follows
  localparam logic [2:0] PhSecond = 3'd3;  // length-only block
  localparam logic [2:0] PhFull   = 3'd4;  // last byte filled a block, closing block follows

  logic [2:0]  st_q, st_d;
  logic [31:0] h_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] cnt_q;          // payload bytes
  logic [6:0]  rnd_q;          // round counter, 127 once the block is done
  logic [5:0]  bld_q;          // build address
  logic [2:0]  phase_q;
  logic [1:0]  oidx_q;
  logic [2:0]  sub_q;          // byte fetch step within a round
  logic [31:0] bits, bits2;
  dmc_wr_t     wr;
  logic [5:0]  rd_addr, rd_off;
  logic [3:0]  gi;
  logic [7:0]  rd_data;
  logic [31:0] mword_q;
  logic [5:0]  left, pos;
  logic [7:0]  bld_byte;
  logic        bld_keep;
  logic        blk_full, tail_long, blk_done;

  assign bits  = {cnt_q[28:0], 3'b000};
  assign bits2 = {2'b00, bits[31:2]} | 32'd1;
  assign left  = cnt_q[5:0];
  // payload bytes sit four above their block offset, so a short tail needs no copy
  assign pos   = bld_q - 6'd4;

  assign blk_full  = !q_item_i.hdr && (left == 6'd63);
  assign tail_long = ((q_item_i.hdr ? left : left + 6'd1) >= 6'd56);

  // byte of the padded tail block at build address
  always_comb begin
    bld_byte = 8'h00;
    bld_keep = 1'b0;
    case (phase_q)
      PhShort: begin
        if (bld_q < 6'd4) bld_byte = bits[8*bld_q[1:0] +: 8];
        else if (bld_q >= 6'd60) bld_byte = bits2[8*bld_q[1:0] +: 8];
        else if (bld_q < left + 6'd4) bld_keep = 1'b1;
        else if (bld_q == left + 6'd4) bld_byte = PadByte;
      end
      PhFirst: begin
        if (pos < left) bld_keep = 1'b1;
        else if (pos == left) bld_byte = PadByte;
      end
      default: begin
        if (bld_q < 6'd4) bld_byte = bits[8*bld_q[1:0] +: 8];
        else if (bld_q >= 6'd60) bld_byte = bits2[8*bld_q[1:0] +: 8];
      end
    endcase
  end

  always_comb begin
    wr = '0;
    if (st_q == StIdle && q_valid_i && !q_item_i.hdr) begin
      wr = '{wr: 1'b1, addr: left + 6'd4, data: q_item_i.data};
    end else if (st_q == StBuild) begin
      wr = '{wr: !bld_keep, addr: bld_q, data: bld_byte};
    end
  end

  // closing blocks are built at their own offsets, payload blocks are shifted by four
  assign rd_off  = (phase_q == PhShort || phase_q == PhSecond) ? 6'd0 : 6'd4;
  assign gi      = md5_g(rnd_q[5:0]);
  assign rd_addr = {gi, 2'b00} + {4'd0, sub_q[1:0]} + rd_off;

  dmc_ram #(.Width(8), .Depth(64)) u_blk (
    .clk_i  (clk_i),
    .we_i   (wr.wr),
    .waddr_i(wr.addr),
    .wdata_i(wr.data),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // one md5 round
  logic [31:0] f, sum, rot;
  logic [5:0]  ri;
  logic [4:0]  sh;
  assign ri = rnd_q[5:0];
  always_comb begin
    unique case (ri[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (d_q & b_q) | (~d_q & c_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    sum = a_q + f + md5_k(ri) + mword_q;
    sh  = md5_s(ri);
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  assign q_pop_o     = (st_q == StIdle) && q_valid_i;
  assign out_valid_o = (st_q == StOut);
  assign word_o      = h_q[oidx_q];
  assign index_o     = oidx_q;
  assign last_o      = (oidx_q == 2'd3);

  assign blk_done = (rnd_q == 7'd127);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (q_valid_i) begin
        if (blk_full) st_d = StRound;
        else if (q_item_i.last) st_d = StBuild;
      end
      StBuild: if (bld_q == 6'd63) st_d = StRound;
      StRound: if (blk_done) begin
        if (phase_q == PhNormal) st_d = StIdle;
        else if (phase_q == PhFirst || phase_q == PhFull) st_d = StBuild;
        else st_d = StOut;
      end
      StOut:   if (out_ready_i && oidx_q == 2'd3) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // sub 0..3 issue byte reads, each byte is captured at the next sub step, sub 5 runs the round
  always_ff @(posedge clk_i) begin
    if (st_q == StRound) begin
      case (sub_q)
        3'd1: mword_q[7:0]   <= rd_data;
        3'd2: mword_q[15:8]  <= rd_data;
        3'd3: mword_q[23:16] <= rd_data;
        3'd4: mword_q[31:24] <= rd_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      h_q[0]  <= IvA; h_q[1] <= IvB; h_q[2] <= IvC; h_q[3] <= IvD;
      a_q     <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
      cnt_q   <= '0;
      rnd_q   <= '0;
      bld_q   <= '0;
      phase_q <= PhNormal;
      oidx_q  <= '0;
      sub_q   <= '0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        StIdle: if (q_valid_i) begin
          a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
          rnd_q <= '0; sub_q <= '0; bld_q <= '0;
          if (!q_item_i.hdr) cnt_q <= cnt_q + 32'd1;
          if (blk_full) phase_q <= q_item_i.last ? PhFull : PhNormal;
          else if (q_item_i.last) phase_q <= tail_long ? PhFirst : PhShort;
          else phase_q <= PhNormal;
        end
        StBuild: begin
          bld_q <= bld_q + 6'd1;
          if (bld_q == 6'd63) begin
            a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
            rnd_q <= '0; sub_q <= '0;
          end
        end
        StRound: begin
          if (blk_done) begin
            h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
            h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
            rnd_q <= '0; sub_q <= '0; bld_q <= '0;
            if (phase_q == PhFirst) phase_q <= PhSecond;
            else if (phase_q == PhFull) phase_q <= PhShort;
          end else begin
            sub_q <= (sub_q == 3'd5) ? 3'd0 : sub_q + 3'd1;
            if (sub_q == 3'd5) begin
              a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
              rnd_q <= (rnd_q[5:0] == 6'd63) ? 7'd127 : rnd_q + 7'd1;
            end
          end
        end
        StOut: if (out_ready_i) begin
          oidx_q <= oidx_q + 2'd1;
          if (oidx_q == 2'd3) begin
            h_q[0] <= IvA; h_q[1] <= IvB; h_q[2] <= IvC; h_q[3] <= IvD;
            cnt_q <= '0; phase_q <= PhNormal;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/dmc_checker.sv
// port-level checks for the checksum block
`default_nettype none
module dmc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[33:32] == 2'd3)))
    else $error("tlast does not match word index");

  a_next_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tdata[33:32] == $past(m_axis_tdata[33:32]) + 2'd1))
    else $error("checksum words not consecutive");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39:34] == 6'd0))
    else $error("pad bits set");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled word changed");
endmodule

bind dxbc_md5_checksum dmc_checker u_chk (.*);
`default_nettype wire
